[hw/rtl/raster_sample_unpack_to_16bit_unit_assert.svh]
// Assertion macros for the raster sample unpacker.
// Each macro takes a label, a condition and what must follow from it.
`ifndef RASTER_SAMPLE_UNPACK_TO_16BIT_UNIT_ASSERT_SVH
`define RASTER_SAMPLE_UNPACK_TO_16BIT_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define RSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsu: same-cycle check failed");
// Next-cycle implication.
`define RSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsu: next-cycle check failed");
`else
`define RSU_ASSERT_IMP(lbl, ante, cons)
`define RSU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/rsu_pkg.sv]
package rsu_pkg;

  localparam int DEF_MAX_WIDTH      = 16384;
  localparam int DEF_MAX_HEIGHT     = 16384;
  localparam int DEF_MAX_COMPONENTS = 4;

  localparam int DEPTH_W    = 5;
  localparam int COMP_CNT_W = 3;
  localparam int DIM_W      = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_DEPTH    = 2'd0,
    REG_COMPONENT_COUNT = 2'd1,
    REG_ROW_WIDTH       = 2'd2,
    REG_IMAGE_HEIGHT    = 2'd3
  } cfg_reg_t;

  // Supported sample depths
  localparam logic [DEPTH_W-1:0] DEPTH_1  = 5'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_2  = 5'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_4  = 5'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_8  = 5'd8;
  localparam logic [DEPTH_W-1:0] DEPTH_16 = 5'd16;

  typedef struct packed {
    logic [DEPTH_W-1:0]    sample_depth;
    logic [COMP_CNT_W-1:0] component_count;
    logic [DIM_W-1:0]      row_width;
    logic [DIM_W-1:0]      image_height;
  } cfg_t;

  typedef struct packed {
    logic [15:0] sample;
    logic [1:0]  component;
    logic        pixel_done;
    logic        row_done;
    logic        image_done;
    logic        last_of_run;
  } result_t;

endpackage

[hw/rtl/rsu_unpack.sv]
module rsu_unpack
  import rsu_pkg::*;
#(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic [7:0] in_data_byte,
  input  logic    in_start_of_image,
  output logic    emit_valid,
  input  logic    emit_ready,
  output result_t emit_data,
  output logic    busy
);

  localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CMP_W = DIM_W + 3;

  logic             hold_v_r, hold_v_nxt;
  logic             packed_r, packed_nxt;
  logic [15:0]      word_r, word_nxt;
  logic [2:0]       rem_r, rem_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [1:0]       comp_r, comp_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             phase_r, phase_nxt;

  logic [CMP_W-1:0]      w_z, h_z, eff_w, eff_h;
  logic [COMP_CNT_W-1:0] c_z, eff_c, comps;
  logic                  pix, row_end, img, last, fire, accept, phase_eff;
  logic [15:0]           field_val;

  // Zero means one, above the build limit saturates
  always_comb begin
    w_z   = (cfg.row_width == '0) ? CMP_W'(1) : CMP_W'(cfg.row_width);
    eff_w = (w_z > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_z;
    h_z   = (cfg.image_height == '0) ? CMP_W'(1) : CMP_W'(cfg.image_height);
    eff_h = (h_z > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : h_z;
    c_z   = (cfg.component_count == '0) ? COMP_CNT_W'(1) : cfg.component_count;
    eff_c = (c_z > COMP_CNT_W'(MAX_COMPONENTS)) ? COMP_CNT_W'(MAX_COMPONENTS) : c_z;
    comps = packed_r ? COMP_CNT_W'(1) : eff_c;
  end

  assign pix     = (COMP_CNT_W'(comp_r) + COMP_CNT_W'(1)) >= comps;
  assign row_end = pix && ((CMP_W'(col_r) + CMP_W'(1)) >= eff_w);
  assign img     = row_end && ((CMP_W'(row_r) + CMP_W'(1)) >= eff_h);
  assign last    = (rem_r == 3'd0) || row_end;

  // Exact scaling of a packed field by bit replication
  always_comb begin
    case (cfg.sample_depth)
      DEPTH_1: field_val = {16{word_r[15]}};
      DEPTH_2: field_val = {8{word_r[15:14]}};
      DEPTH_4: field_val = {4{word_r[15:12]}};
      default: field_val = word_r;
    endcase
    if (!packed_r) begin
      field_val = word_r;
    end
  end

  assign emit_valid            = hold_v_r;
  assign emit_data.sample      = field_val;
  assign emit_data.component   = comp_r;
  assign emit_data.pixel_done  = pix;
  assign emit_data.row_done    = row_end;
  assign emit_data.image_done  = img;
  assign emit_data.last_of_run = last;

  assign fire      = hold_v_r && emit_ready;
  assign in_ready  = !hold_v_r || (fire && last);
  assign accept    = in_valid && in_ready;
  assign busy      = hold_v_r;
  assign phase_eff = in_start_of_image ? 1'b0 : phase_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    packed_nxt = packed_r;
    word_nxt   = word_r;
    rem_nxt    = rem_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    comp_nxt   = comp_r;
    held_nxt   = held_r;
    phase_nxt  = phase_r;

    // Advance the position counters on each emitted sample
    if (fire) begin
      if (!pix) begin
        comp_nxt = comp_r + 2'd1;
      end else begin
        comp_nxt = 2'd0;
        if (!row_end) begin
          col_nxt = col_r + COL_W'(1);
        end else begin
          col_nxt = '0;
          row_nxt = img ? '0 : row_r + ROW_W'(1);
        end
      end
      if (last) begin
        hold_v_nxt = 1'b0;
      end else begin
        word_nxt[15:8] = 8'(word_r[15:8] << cfg.sample_depth);
        rem_nxt        = rem_r - 3'd1;
      end
    end

    if (accept) begin
      if (in_start_of_image) begin
        col_nxt   = '0;
        row_nxt   = '0;
        comp_nxt  = 2'd0;
        phase_nxt = 1'b0;
      end
      case (cfg.sample_depth)
        DEPTH_1, DEPTH_2, DEPTH_4: begin
          hold_v_nxt = 1'b1;
          packed_nxt = 1'b1;
          word_nxt   = {in_data_byte, 8'h00};
          comp_nxt   = 2'd0;
          case (cfg.sample_depth)
            DEPTH_1: rem_nxt = 3'd7;
            DEPTH_2: rem_nxt = 3'd3;
            default: rem_nxt = 3'd1;
          endcase
        end
        DEPTH_8: begin
          hold_v_nxt = 1'b1;
          packed_nxt = 1'b0;
          word_nxt   = {in_data_byte, in_data_byte};
          rem_nxt    = 3'd0;
        end
        DEPTH_16: begin
          if (!phase_eff) begin
            held_nxt  = in_data_byte;
            phase_nxt = 1'b1;
          end else begin
            phase_nxt  = 1'b0;
            hold_v_nxt = 1'b1;
            packed_nxt = 1'b0;
            word_nxt   = {held_r, in_data_byte};
            rem_nxt    = 3'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      comp_r   <= 2'd0;
      held_r   <= 8'h00;
      phase_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      comp_r   <= comp_nxt;
      held_r   <= held_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    packed_r <= packed_nxt;
    word_r   <= word_nxt;
    rem_r    <= rem_nxt;
  end

endmodule

[hw/rtl/rsu_out_reg.sv]
module rsu_out_reg
  import rsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    emit_valid,
  output logic    emit_ready,
  input  result_t emit_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  assign emit_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (emit_ready) begin
      valid_nxt = emit_valid;
      data_nxt  = emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[hw/rtl/raster_sample_unpack_to_16bit_unit.sv]
// Raster sample unpacker: takes raster bytes in file order and delivers
// 16-bit samples, one per transfer on the out_ channel. At depths 1, 2 and 4
// each byte is split into 8, 4 or 2 fields, most significant first, and each
// field is scaled exactly to full range; pad fields after the last pixel of
// a row are dropped, so every row starts on a byte boundary. At depth 8 a
// byte becomes byte*257, at depth 16 two bytes (high first) form one sample,
// and other depths consume bytes without output. Each sample carries its
// component index and end-of-pixel, end-of-row, end-of-image and last-of-byte
// flags. Throughput: one sample leaves per cycle from the output register
// while out_ready is high, and a byte holds the unpack register until its
// last sample, early when a row ends inside it, has moved on; a depth-16
// pair takes two input transfers for one sample, and a byte that yields
// nothing is absorbed in the cycle of its transfer. A new byte is taken in
// the same cycle the previous byte's last sample moves into the output
// register. Write the configuration registers only while the block is idle.
`include "raster_sample_unpack_to_16bit_unit_assert.svh"

module raster_sample_unpack_to_16bit_unit
  import rsu_pkg::*;
#(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // raster byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_start_of_image,
  // sample output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_sample,
  output logic [1:0]            out_component,
  output logic                  out_pixel_done,
  output logic                  out_row_done,
  output logic                  out_image_done,
  output logic                  out_last_of_run
);

  cfg_t    cfg_r, cfg_nxt;
  logic    emit_valid, emit_ready, busy;
  result_t emit_data, out_data;

  // Configuration registers: hold until written
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_DEPTH:    cfg_nxt.sample_depth    = cfg_wdata[DEPTH_W-1:0];
        REG_COMPONENT_COUNT: cfg_nxt.component_count = cfg_wdata[COMP_CNT_W-1:0];
        REG_ROW_WIDTH:       cfg_nxt.row_width       = cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    cfg_nxt.image_height    = cfg_wdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_depth    <= DEPTH_8;
      cfg_r.component_count <= COMP_CNT_W'(1);
      cfg_r.row_width       <= DIM_W'(1);
      cfg_r.image_height    <= DIM_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Unpack register: holds one byte and steps through its fields
  rsu_unpack #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_unpack (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_start_of_image (in_start_of_image),
    .emit_valid        (emit_valid),
    .emit_ready        (emit_ready),
    .emit_data         (emit_data),
    .busy              (busy)
  );

  // Result register: parts the unpack stage from the consumer
  rsu_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_sample      = out_data.sample;
  assign out_component   = out_data.component;
  assign out_pixel_done  = out_data.pixel_done;
  assign out_row_done    = out_data.row_done;
  assign out_image_done  = out_data.image_done;
  assign out_last_of_run = out_data.last_of_run;

  // End of image is also end of row and of pixel
  `RSU_ASSERT_IMP(a_image_end_nests, out_valid && out_image_done, out_row_done && out_pixel_done)
  // Input stalls only while a byte still has fields to deliver
  `RSU_ASSERT_IMP(a_stall_only_busy, !in_ready, busy)
  // A waiting sample that is not its byte's last means the byte is still held
  `RSU_ASSERT_IMP(a_mid_run_held, out_valid && !out_last_of_run, busy)

endmodule
